// ===== src/dea_pkg.sv =====
// dea_pkg: shared constants, control struct and bit-string helper functions
// for the determinant excitation analyzer; no dependencies
`timescale 1ns / 1ps

package dea_pkg;

    localparam int STRING_BITS_DEF = 64;
    localparam int ORB_W           = 6;   // orbital index width
    localparam int CNT_W           = 7;   // orbital count / popcount width
    localparam int ADDR_W          = 24;  // flattened integral address width
    localparam int LEVEL_W         = 6;
    localparam int PDATA_W         = 32;
    localparam int PADDR_W         = 3;

    // register word indexes on the config port
    localparam logic REG_ORBITAL_COUNT = 1'b0;

    localparam logic [CNT_W-1:0] ORBITAL_COUNT_RST = 7'd64;

    localparam logic [LEVEL_W-1:0] LEVEL_SINGLE = 6'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_DOUBLE = 6'd2;

    localparam logic [63:0] M1  = 64'h5555555555555555;
    localparam logic [63:0] M2  = 64'h3333333333333333;
    localparam logic [63:0] M4  = 64'h0f0f0f0f0f0f0f0f;
    localparam logic [63:0] M8  = 64'h00ff00ff00ff00ff;
    localparam logic [63:0] M16 = 64'h0000ffff0000ffff;
    localparam logic [63:0] M32 = 64'h00000000ffffffff;

    // load strobes for the address arithmetic stages
    typedef struct packed {
        logic ld4;
        logic ld5;
        logic ld6;
    } t_addr_ctl;

    function automatic logic [CNT_W-1:0] f_ones(input logic [63:0] x);
        logic [63:0] y;
        begin
            y = (x & M1) + ((x >> 1) & M1);
            y = (y & M2) + ((y >> 2) & M2);
            y = (y & M4) + ((y >> 4) & M4);
            y = (y & M8) + ((y >> 8) & M8);
            y = (y & M16) + ((y >> 16) & M16);
            y = (y & M32) + ((y >> 32) & M32);
            return y[CNT_W-1:0];
        end
    endfunction

    // position of the lowest set bit, zero for an empty string
    function automatic logic [ORB_W-1:0] f_lowest(input logic [63:0] x);
        logic [63:0]      iso;
        logic [ORB_W-1:0] c;
        begin
            iso = x & (~x + 64'd1);
            c   = 6'd63;
            if ((iso & M32) != 64'd0) c = c - 6'd32;
            if ((iso & M16) != 64'd0) c = c - 6'd16;
            if ((iso & M8) != 64'd0)  c = c - 6'd8;
            if ((iso & M4) != 64'd0)  c = c - 6'd4;
            if ((iso & M2) != 64'd0)  c = c - 6'd2;
            if ((iso & M1) != 64'd0)  c = c - 6'd1;
            if (x == 64'd0) c = 6'd0;
            return c;
        end
    endfunction

    // single bit at position k, empty when k reaches 64
    function automatic logic [63:0] f_bitat(input logic [CNT_W-1:0] k);
        begin
            return k[6] ? 64'd0 : (64'd1 << k[5:0]);
        end
    endfunction

    // parity of bits of s strictly between p and q (p and q taken in either order)
    function automatic logic f_parity_between(input logic [ORB_W-1:0] p,
                                              input logic [ORB_W-1:0] q,
                                              input logic [63:0] s);
        logic [ORB_W-1:0] hi;
        logic [ORB_W-1:0] lo;
        logic [63:0]      mask;
        begin
            hi   = (p > q) ? p : q;
            lo   = (p > q) ? q : p;
            mask = f_bitat({1'b0, hi}) - f_bitat(7'({1'b0, lo}) + 7'd1);
            return ^(s & mask);
        end
    endfunction

endpackage

// ===== src/dea_addr_pipe.sv =====
// dea_addr_pipe: three-stage multiply-add chain for flattened integral
// addresses (horner form over the orbital count); uses dea_pkg
`timescale 1ns / 1ps

module dea_addr_pipe (
    input  logic                        i_clk,
    input  dea_pkg::t_addr_ctl          i_ctl,
    input  logic [dea_pkg::CNT_W-1:0]   i_n,
    input  logic [dea_pkg::ORB_W-1:0]   i_hole_low,
    input  logic [dea_pkg::ORB_W-1:0]   i_hole_high,
    input  logic [dea_pkg::ORB_W-1:0]   i_particle_low,
    input  logic [dea_pkg::ORB_W-1:0]   i_particle_high,
    output logic [dea_pkg::ADDR_W-1:0]  o_ai,
    output logic [dea_pkg::ADDR_W-1:0]  o_aibj,
    output logic [dea_pkg::ADDR_W-1:0]  o_ajbi
);

    localparam int W4 = 14;  // a*n + i
    localparam int W5 = 20;  // (a*n + i)*n + b
    localparam int WP = 27;  // full product of the last step

    // stage 4: a*n plus hole
    logic [W4-1:0] w_an;
    logic [W4-1:0] r_ai, r_aj;
    logic [dea_pkg::ORB_W-1:0] r4_i, r4_j, r4_b;

    // stage 5: times n plus b
    logic [W5-1:0] w_aib, w_ajb;
    logic [W5-1:0] r_aib, r_ajb;
    logic [W4-1:0] r5_ai;
    logic [dea_pkg::ORB_W-1:0] r5_i, r5_j;

    // stage 6: times n plus the other hole
    logic [WP-1:0] w_pi, w_pj;
    logic [dea_pkg::ADDR_W-1:0] n_aibj, n_ajbi;
    logic [dea_pkg::ADDR_W-1:0] r_aibj, r_ajbi, r6_ai;

    assign w_an  = W4'(i_particle_low) * W4'(i_n);
    assign w_aib = W5'(r_ai) * W5'(i_n) + W5'(r4_b);
    assign w_ajb = W5'(r_aj) * W5'(i_n) + W5'(r4_b);
    assign w_pi  = WP'(r_aib) * WP'(i_n);
    assign w_pj  = WP'(r_ajb) * WP'(i_n);
    assign n_aibj = w_pi[dea_pkg::ADDR_W-1:0] + dea_pkg::ADDR_W'(r5_j);
    assign n_ajbi = w_pj[dea_pkg::ADDR_W-1:0] + dea_pkg::ADDR_W'(r5_i);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld4) begin
            r_ai <= w_an + W4'(i_hole_low);
            r_aj <= w_an + W4'(i_hole_high);
            r4_i <= i_hole_low;
            r4_j <= i_hole_high;
            r4_b <= i_particle_high;
        end
        if (i_ctl.ld5) begin
            r_aib <= w_aib;
            r_ajb <= w_ajb;
            r5_ai <= r_ai;
            r5_i  <= r4_i;
            r5_j  <= r4_j;
        end
        if (i_ctl.ld6) begin
            r_aibj <= n_aibj;
            r_ajbi <= n_ajbi;
            r6_ai  <= dea_pkg::ADDR_W'(r5_ai);
        end
    end

    assign o_ai   = r6_ai;
    assign o_aibj = r_aibj;
    assign o_ajbi = r_ajbi;

endmodule

// ===== src/determinant_excitation_analyzer_core.sv =====
// determinant_excitation_analyzer_core: top level, compares two occupation bit strings
// and reports excitation level, orbitals, phase and addresses; uses dea_pkg, dea_addr_pipe
// six register stages lie between the input transfer and o_valid; one transfer per
// cycle is sustained while i_ready stays high
// each stage has its own valid bit, so bubbles fill even while output stalls
// reset (i_rst_n low, synchronous): pipeline empty, orbital_count = 64
`timescale 1ns / 1ps

module determinant_excitation_analyzer_core #(
    parameter int STRING_BITS = dea_pkg::STRING_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // apb-style configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dea_pkg::PADDR_W-1:0]   paddr,
    input  logic [dea_pkg::PDATA_W-1:0]   pwdata,
    output logic [dea_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [63:0]                   i_det_left,
    input  logic [63:0]                   i_det_right,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dea_pkg::LEVEL_W-1:0]   o_level,
    output logic [dea_pkg::ORB_W-1:0]     o_hole_low,
    output logic [dea_pkg::ORB_W-1:0]     o_hole_high,
    output logic [dea_pkg::ORB_W-1:0]     o_particle_low,
    output logic [dea_pkg::ORB_W-1:0]     o_particle_high,
    output logic                          o_sign_negative,
    output logic                          o_crossed,
    output logic [dea_pkg::ADDR_W-1:0]    o_first_index,
    output logic [dea_pkg::ADDR_W-1:0]    o_second_index
);

    localparam int SB = STRING_BITS;
    localparam int NSTG = 6;
    localparam int ORB_W = dea_pkg::ORB_W;
    localparam int CNT_W = dea_pkg::CNT_W;
    localparam int LEVEL_W = dea_pkg::LEVEL_W;

    // ---------------------------------------------------------------
    // configuration register
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] r_orbital_count;
    logic             w_cfg_wr;
    logic             w_reg_sel;

    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[2] == dea_pkg::REG_ORBITAL_COUNT);
    assign w_cfg_wr  = psel & penable & pwrite & pready & w_reg_sel;
    // low address bits only pick bytes inside a word and are ignored
    assign prdata    = w_reg_sel ? dea_pkg::PDATA_W'(r_orbital_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orbital_count <= dea_pkg::ORBITAL_COUNT_RST;
        end else if (w_cfg_wr) begin
            r_orbital_count <= pwdata[CNT_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // pipeline flow control: a stage loads when empty or when the
    // stage after it moves on
    // ---------------------------------------------------------------
    logic [NSTG:1] r_vld;
    logic [NSTG:1] w_ld;

    always_comb begin
        w_ld[NSTG] = !r_vld[NSTG] || i_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_ld[k] = !r_vld[k] || w_ld[k+1];
        end
    end

    assign o_ready = w_ld[1];
    assign o_valid = r_vld[NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ld[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 1: trim to the string width, split into holes and particles
    // ---------------------------------------------------------------
    logic [SB-1:0] w_left, w_right;
    logic [SB-1:0] r1_left, r1_holes, r1_parts;

    assign w_left  = i_det_left[SB-1:0];
    assign w_right = i_det_right[SB-1:0];

    always_ff @(posedge i_clk) begin
        if (w_ld[1]) begin
            r1_left  <= w_left;
            r1_holes <= w_left & ~w_right;
            r1_parts <= w_right & ~w_left;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: hole and particle counts, lowest of each, and the strings
    // with their lowest bit cleared for the second search
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] r2_nh, r2_np;
    logic [ORB_W-1:0] r2_i, r2_a;
    logic [SB-1:0]    r2_left, r2_holes2, r2_parts2;

    always_ff @(posedge i_clk) begin
        if (w_ld[2]) begin
            r2_nh     <= dea_pkg::f_ones(64'(r1_holes));
            r2_np     <= dea_pkg::f_ones(64'(r1_parts));
            r2_i      <= dea_pkg::f_lowest(64'(r1_holes));
            r2_a      <= dea_pkg::f_lowest(64'(r1_parts));
            r2_left   <= r1_left;
            r2_holes2 <= r1_holes & (r1_holes - SB'(1));
            r2_parts2 <= r1_parts & (r1_parts - SB'(1));
        end
    end

    // ---------------------------------------------------------------
    // stage 3: excitation level and the orbitals it keeps
    // ---------------------------------------------------------------
    logic [CNT_W:0]   w_sum;
    logic [LEVEL_W-1:0] w_level;
    logic [ORB_W-1:0] w_j0, w_b0;
    logic [ORB_W-1:0] n3_i, n3_j, n3_a, n3_b;
    logic [LEVEL_W-1:0] r3_level;
    logic [ORB_W-1:0] r3_i, r3_j, r3_a, r3_b;
    logic [SB-1:0]    r3_left;

    assign w_sum   = (CNT_W + 1)'(r2_nh) + (CNT_W + 1)'(r2_np);
    assign w_level = w_sum[LEVEL_W:1];
    assign w_j0    = dea_pkg::f_lowest(64'(r2_holes2));
    assign w_b0    = dea_pkg::f_lowest(64'(r2_parts2));

    always_comb begin
        // no-excitation and triple-or-higher: lowest hole and particle only
        n3_i = r2_i;
        n3_a = r2_a;
        n3_j = '0;
        n3_b = '0;
        if (w_level == dea_pkg::LEVEL_SINGLE) begin
            n3_i = (r2_nh == CNT_W'(1)) ? r2_i : '0;
            n3_a = (r2_np == CNT_W'(1)) ? r2_a : '0;
        end else if (w_level == dea_pkg::LEVEL_DOUBLE) begin
            // a third hole (or particle) without its partner zeroes both
            n3_i = (r2_nh == CNT_W'(1) || r2_nh == CNT_W'(2)) ? r2_i : '0;
            n3_j = (r2_nh == CNT_W'(2)) ? w_j0 : '0;
            n3_a = (r2_np == CNT_W'(1) || r2_np == CNT_W'(2)) ? r2_a : '0;
            n3_b = (r2_np == CNT_W'(2)) ? w_b0 : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[3]) begin
            r3_level <= w_level;
            r3_i     <= n3_i;
            r3_j     <= n3_j;
            r3_a     <= n3_a;
            r3_b     <= n3_b;
            r3_left  <= r2_left;
        end
    end

    // ---------------------------------------------------------------
    // stage 4: ordering flag and fermionic phase
    // ---------------------------------------------------------------
    logic w_is_single, w_is_double, w_crossed;
    logic w_par_a, w_par_b, w_neg;
    logic [LEVEL_W-1:0] r4_level;
    logic [ORB_W-1:0]   r4_i, r4_j, r4_a, r4_b;
    logic               r4_neg, r4_crossed;

    assign w_is_single = (r3_level == dea_pkg::LEVEL_SINGLE);
    assign w_is_double = (r3_level == dea_pkg::LEVEL_DOUBLE);
    assign w_crossed   = w_is_double && ((r3_a > r3_j) || (r3_i > r3_b));

    // crossed pairs are (b,i),(a,j); otherwise (b,j),(a,i); a single uses (a,i)
    assign w_par_a = dea_pkg::f_parity_between(r3_a, w_crossed ? r3_j : r3_i,
                                               64'(r3_left));
    assign w_par_b = dea_pkg::f_parity_between(r3_b, w_crossed ? r3_i : r3_j,
                                               64'(r3_left));
    assign w_neg   = w_is_single ? w_par_a :
                     w_is_double ? (w_par_a ^ w_par_b) : 1'b0;

    always_ff @(posedge i_clk) begin
        if (w_ld[4]) begin
            r4_level   <= r3_level;
            r4_i       <= r3_i;
            r4_j       <= r3_j;
            r4_a       <= r3_a;
            r4_b       <= r3_b;
            r4_neg     <= w_neg;
            r4_crossed <= w_crossed;
        end
    end

    // ---------------------------------------------------------------
    // address chain runs beside stages 4 to 6
    // ---------------------------------------------------------------
    dea_pkg::t_addr_ctl w_addr_ctl;
    logic [dea_pkg::ADDR_W-1:0] w_ai, w_aibj, w_ajbi;

    assign w_addr_ctl.ld4 = w_ld[4];
    assign w_addr_ctl.ld5 = w_ld[5];
    assign w_addr_ctl.ld6 = w_ld[6];

    dea_addr_pipe u_addr (
        .i_clk           (i_clk),
        .i_ctl           (w_addr_ctl),
        .i_n             (r_orbital_count),
        .i_hole_low      (r3_i),
        .i_hole_high     (r3_j),
        .i_particle_low  (r3_a),
        .i_particle_high (r3_b),
        .o_ai            (w_ai),
        .o_aibj          (w_aibj),
        .o_ajbi          (w_ajbi)
    );

    // ---------------------------------------------------------------
    // stages 5 and 6: carry the result fields alongside the multipliers
    // ---------------------------------------------------------------
    logic [LEVEL_W-1:0] r5_level, r6_level;
    logic [ORB_W-1:0]   r5_i, r5_j, r5_a, r5_b;
    logic [ORB_W-1:0]   r6_i, r6_j, r6_a, r6_b;
    logic               r5_neg, r5_crossed, r6_neg, r6_crossed;

    always_ff @(posedge i_clk) begin
        if (w_ld[5]) begin
            r5_level   <= r4_level;
            r5_i       <= r4_i;
            r5_j       <= r4_j;
            r5_a       <= r4_a;
            r5_b       <= r4_b;
            r5_neg     <= r4_neg;
            r5_crossed <= r4_crossed;
        end
        if (w_ld[6]) begin
            r6_level   <= r5_level;
            r6_i       <= r5_i;
            r6_j       <= r5_j;
            r6_a       <= r5_a;
            r6_b       <= r5_b;
            r6_neg     <= r5_neg;
            r6_crossed <= r5_crossed;
        end
    end

    // output select: single gives a*n+i, double orders its two addresses
    always_comb begin
        o_first_index  = '0;
        o_second_index = '0;
        if (r6_level == dea_pkg::LEVEL_SINGLE) begin
            o_first_index = w_ai;
        end else if (r6_level == dea_pkg::LEVEL_DOUBLE) begin
            o_first_index  = r6_crossed ? w_ajbi : w_aibj;
            o_second_index = r6_crossed ? w_aibj : w_ajbi;
        end
    end

    assign o_level         = r6_level;
    assign o_hole_low      = r6_i;
    assign o_hole_high     = r6_j;
    assign o_particle_low  = r6_a;
    assign o_particle_high = r6_b;
    assign o_sign_negative = r6_neg;
    assign o_crossed       = r6_crossed;

endmodule
